FILE: src/msie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msie_pkg: shared types and constants for the MIPS subset executor
// Instruction opcodes, function codes, status codes, the word structs of the
// two channels and the writeback/state-update structs between the modules.
// ----------------------------------------------------------------------------
package msie_pkg;

	// Primary opcodes (instr[31:26])
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_ANDI    = 6'h0c;
	localparam logic [5:0] OP_ORI     = 6'h0d;
	localparam logic [5:0] OP_XORI    = 6'h0e;
	localparam logic [5:0] OP_LUI     = 6'h0f;
	localparam logic [5:0] OP_DADDIU  = 6'h19;

	// SPECIAL function codes (instr[5:0])
	localparam logic [5:0] FN_SYNC = 6'h0f;
	localparam logic [5:0] FN_SLT  = 6'h2a;
	localparam logic [5:0] FN_SLTU = 6'h2b;

	// Configuration register indexes
	localparam logic CFG_LITTLE_ENDIAN = 1'b0;
	localparam logic CFG_START_ADDRESS = 1'b1;

	// Result status
	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_UNSUPPORTED  = 2'd1,
		ST_FETCH_FAILED = 2'd2,
		ST_WIDE_OP      = 2'd3
	} status_t;

	// Input word: one fetched instruction
	typedef struct packed {
		logic [31:0] instr_word;
		logic        fetch_failed;
	} instr_t;

	// Output word: one executed instruction
	typedef struct packed {
		logic [31:0] next_fetch_address;
		logic        reg_written;
		logic [4:0]  dest_index;
		logic [31:0] dest_value;
		status_t     status;
	} result_t;

	// Register file writeback
	typedef struct packed {
		logic        en;
		logic [4:0]  idx;
		logic [31:0] val;
	} wb_t;

	// Architectural state update from the execute unit
	typedef struct packed {
		logic        advance;   // instruction ran: PC and branch state move
		logic        taken;     // branch taken, target goes pending
		logic [31:0] target;
		logic [31:0] next_pc;
	} state_upd_t;

	// Byte swap of a fetched word
	function automatic logic [31:0] swap32(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage

FILE: src/msie_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msie_regfile: general register file
// Memory with registered two-port read taken when a word is loaded, per-entry
// valid bits so unwritten entries read as zero after reset, and a bypass for
// a write landing on the same edge as the read.
// ----------------------------------------------------------------------------
module msie_regfile
	import msie_pkg::*;
#(
	parameter int REG_COUNT = 32,
	localparam int IDX_W = $clog2(REG_COUNT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rs_addr,
	input  logic [IDX_W-1:0] rt_addr,
	input  wb_t              wb,
	output logic [31:0]      rs_data,
	output logic [31:0]      rt_data
);

	logic [31:0]          mem [REG_COUNT];
	logic [REG_COUNT-1:0] valid_q;
	logic [31:0]          rs_mem_s1, rt_mem_s1, fwd_val_s1;
	logic                 rs_vld_s1, rt_vld_s1, rs_fwd_s1, rt_fwd_s1;
	logic [IDX_W-1:0]     wb_idx;

	assign wb_idx = IDX_W'(wb.idx);

	// Storage: one write port, registered reads
	always_ff @(posedge clk) begin
		if (wb.en) begin
			mem[wb_idx] <= wb.val;
		end
		if (rd_en) begin
			rs_mem_s1  <= mem[rs_addr];
			rt_mem_s1  <= mem[rt_addr];
			fwd_val_s1 <= wb.val;
		end
	end

	// Valid bits and read-side selects; entry zero is never written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rs_vld_s1 <= 1'b0;
			rt_vld_s1 <= 1'b0;
			rs_fwd_s1 <= 1'b0;
			rt_fwd_s1 <= 1'b0;
		end else begin
			if (wb.en) begin
				valid_q[wb_idx] <= 1'b1;
			end
			if (rd_en) begin
				rs_vld_s1 <= valid_q[rs_addr];
				rt_vld_s1 <= valid_q[rt_addr];
				rs_fwd_s1 <= wb.en && (wb_idx == rs_addr);
				rt_fwd_s1 <= wb.en && (wb_idx == rt_addr);
			end
		end
	end

	// Operand select: same-edge write, stored value, or zero
	assign rs_data = rs_fwd_s1 ? fwd_val_s1 : (rs_vld_s1 ? rs_mem_s1 : '0);
	assign rt_data = rt_fwd_s1 ? fwd_val_s1 : (rt_vld_s1 ? rt_mem_s1 : '0);

endmodule

FILE: src/msie_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msie_exec: decode and execute
// Decodes one instruction word, computes the ALU result, branch decision and
// next PC, and forms the result word, writeback and state update.
// ----------------------------------------------------------------------------
module msie_exec
	import msie_pkg::*;
(
	input  logic [31:0] instr,
	input  logic        fetch_failed,
	input  logic [31:0] rs_val,
	input  logic [31:0] rt_val,
	input  logic [31:0] pc,
	input  logic        br_pend,
	input  logic [31:0] br_tgt,
	output result_t     result,
	output wb_t         wb,
	output state_upd_t  upd
);

	logic [5:0]  op, fn;
	logic [4:0]  rt, rd;
	logic [31:0] imm, simm, pc_plus4;
	logic        wr, taken;
	logic [4:0]  widx;
	logic [31:0] wval;
	status_t     status;

	assign op       = instr[31:26];
	assign rt       = instr[20:16];
	assign rd       = instr[15:11];
	assign fn       = instr[5:0];
	assign imm      = {16'h0, instr[15:0]};
	assign simm     = {{16{instr[15]}}, instr[15:0]};
	assign pc_plus4 = pc + 32'd4;

	// Decode and ALU
	always_comb begin
		wr     = 1'b0;
		widx   = rt;
		wval   = '0;
		taken  = 1'b0;
		status = ST_OK;
		case (op)
			OP_SPECIAL: begin
				widx = rd;
				case (fn)
					FN_SLT: begin
						wr   = 1'b1;
						wval = {31'h0, $signed(rs_val) < $signed(rt_val)};
					end
					FN_SLTU: begin
						wr   = 1'b1;
						wval = {31'h0, rs_val < rt_val};
					end
					FN_SYNC: ;
					default: status = ST_UNSUPPORTED;
				endcase
			end
			OP_BEQ:    taken = (rs_val == rt_val);
			OP_BNE:    taken = (rs_val != rt_val);
			OP_ADDIU: begin
				wr   = 1'b1;
				wval = rs_val + simm;
			end
			OP_ANDI: begin
				wr   = 1'b1;
				wval = rs_val & imm;
			end
			OP_ORI: begin
				wr   = 1'b1;
				wval = rs_val | imm;
			end
			OP_XORI: begin
				wr   = 1'b1;
				wval = rs_val ^ imm;
			end
			OP_LUI: begin
				wr   = 1'b1;
				wval = {instr[15:0], 16'h0};
			end
			OP_DADDIU: status = ST_WIDE_OP;
			default:   status = ST_UNSUPPORTED;
		endcase
		// r0 writes are dropped; a failed fetch runs nothing
		if (widx == 5'd0 || fetch_failed) begin
			wr = 1'b0;
		end
		if (fetch_failed) begin
			taken  = 1'b0;
			status = ST_FETCH_FAILED;
		end
	end

	// State update: delay slot takes the pending target
	always_comb begin
		upd.advance = !fetch_failed;
		upd.taken   = taken;
		upd.target  = pc_plus4 + {simm[29:0], 2'b00};
		upd.next_pc = fetch_failed ? pc : (br_pend ? br_tgt : pc_plus4);
	end

	assign wb.en  = wr;
	assign wb.idx = widx;
	assign wb.val = wval;

	// Result word
	always_comb begin
		result.next_fetch_address = upd.next_pc;
		result.reg_written        = wr;
		result.dest_index         = wr ? widx : 5'd0;
		result.dest_value         = wr ? wval : '0;
		result.status             = status;
	end

endmodule

FILE: src/mips_subset_instruction_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor: MIPS32 integer subset, one word per cycle
// Executes SLT, SLTU, SYNC, BEQ, BNE, ADDIU, ANDI, ORI, XORI and LUI with a
// branch delay slot, reporting next fetch address, writeback and status.
// ----------------------------------------------------------------------------
// Throughput is one instruction word per clock while the result side does not
// stall; the path runs through an input register that also launches the
// register file read and a result register after the decode/ALU logic. A new
// word is taken while the result register still holds an undelivered one, as
// long as the execute stage can move, so instr_ready depends only on the input
// stage and the result side. The register file is a memory with registered
// reads; per-entry valid bits make it read as zero after reset, so no clearing
// pass is needed. A write to start_address (index 1) reloads the PC and drops a
// pending branch; write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module mips_subset_instruction_executor
	import msie_pkg::*;
#(
	parameter int REG_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	output logic        instr_ready,
	input  instr_t      instr,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int IDX_W = $clog2(REG_COUNT);

	logic        little_endian_q;
	logic [31:0] pc_q, br_tgt_q;
	logic        br_pend_q;
	logic [31:0] instr_s1;
	logic        failed_s1, valid_s1;
	result_t     result_s2;
	logic        valid_s2;
	logic        load, fire;
	logic [31:0] word_in;
	logic [31:0] rs_val, rt_val;
	result_t     exec_result;
	wb_t         exec_wb, wb;
	state_upd_t  upd;

	// Handshake: execute moves when the result register is free or draining
	assign fire        = valid_s1 && (!valid_s2 || result_ready);
	assign instr_ready = !valid_s1 || fire;
	assign load        = instr_valid && instr_ready;

	assign word_in = little_endian_q ? swap32(instr.instr_word) : instr.instr_word;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			instr_s1  <= word_in;
			failed_s1 <= instr.fetch_failed;
		end
	end

	// Register file, read launched with the load
	assign wb.en  = exec_wb.en && fire;
	assign wb.idx = exec_wb.idx;
	assign wb.val = exec_wb.val;

	msie_regfile #(
		.REG_COUNT (REG_COUNT)
	) u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (load),
		.rs_addr (IDX_W'(word_in[25:21])),
		.rt_addr (IDX_W'(word_in[20:16])),
		.wb      (wb),
		.rs_data (rs_val),
		.rt_data (rt_val)
	);

	msie_exec u_exec (
		.instr        (instr_s1),
		.fetch_failed (failed_s1),
		.rs_val       (rs_val),
		.rt_val       (rt_val),
		.pc           (pc_q),
		.br_pend      (br_pend_q),
		.br_tgt       (br_tgt_q),
		.result       (exec_result),
		.wb           (exec_wb),
		.upd          (upd)
	);

	// Configuration and architectural PC/branch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			little_endian_q <= 1'b0;
			pc_q            <= '0;
			br_pend_q       <= 1'b0;
			br_tgt_q        <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LITTLE_ENDIAN: little_endian_q <= cfg_data[0];
				CFG_START_ADDRESS: begin
					pc_q      <= cfg_data;
					br_pend_q <= 1'b0;
				end
				default: ;
			endcase
		end else if (fire && upd.advance) begin
			pc_q      <= upd.next_pc;
			br_pend_q <= upd.taken;
			if (upd.taken) begin
				br_tgt_q <= upd.target;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= exec_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule
